// ===== src/brse_pkg.sv =====
// shared types and constants for the bitmap row span extractor
// used by every module under src; no dependencies of its own
package brse_pkg;

    // raster limits
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_ROWS  = 4096;

    // field widths
    localparam int COL_W  = 13;
    localparam int LEFT_W = 12;
    localparam int ROW_W  = 12;
    localparam int PIX_W  = 8;

    // lanes and span counts per byte
    localparam int LANES     = 8;
    localparam int MAX_SPANS = 5;
    localparam int CNT_W     = 3;

    // queue sizing: the step-level queue is tracked by count inside a larger fifo
    localparam int STEP_Q_DEPTH = 8;
    localparam int OUT_PER_STEP = 4;
    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_AW      = 4;
    localparam int PTR_W        = FIFO_AW + 1;
    localparam int SPACE_LIMIT  = FIFO_DEPTH - 2 * MAX_SPANS;

    // output word padding to whole bytes
    localparam int SPAN_BITS = LEFT_W + COL_W + ROW_W;
    localparam int OUT_DATA_W = ((SPAN_BITS + 7) / 8) * 8;

    // one span, left column in the lowest bits
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  right;
        logic [LEFT_W-1:0] left;
    } span_t;

    // a span slot that may or may not be in use
    typedef struct packed {
        logic  valid;
        span_t span;
    } cand_t;

    // queue status back to the top level
    typedef struct packed {
        logic             space_ok;
        logic [PTR_W-1:0] fill;
    } q_stat_t;

endpackage

// ===== src/brse_lane.sv =====
// one pixel lane of the row scanner: run start/stop detection for one pixel
// depends on brse_pkg; lanes are chained through the open and left signals
module brse_lane
    import brse_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic [COL_W-1:0]  column,
    input  logic [COL_W-1:0]  width,
    input  logic [ROW_W-1:0]  row,
    input  logic              pixel,
    input  logic              open_in,
    input  logic [LEFT_W-1:0] left_in,
    output logic              open_out,
    output logic [LEFT_W-1:0] left_out,
    output cand_t             cand
);

    logic [COL_W-1:0] lane_col;
    logic             active;

    // this lane's column and whether it lies inside the row
    assign lane_col = column + COL_W'(LANE);
    assign active   = lane_col < width;

    // run state passes through unchanged past the row end
    assign open_out = active ? pixel : open_in;
    assign left_out = (active && pixel && !open_in) ? lane_col[LEFT_W-1:0] : left_in;

    // a clear pixel closes an open run
    assign cand.valid      = active && open_in && !pixel;
    assign cand.span.left  = left_in;
    assign cand.span.right = lane_col;
    assign cand.span.row   = row;

endmodule

// ===== src/brse_merge.sv =====
// merge stage: packs the spans found by the lanes and the row-end span in order
// depends on brse_pkg; fed by the brse_lane chain
module brse_merge
    import brse_pkg::*;
(
    input  cand_t            cands [LANES+1],
    output span_t            spans [MAX_SPANS],
    output logic [CNT_W-1:0] count
);

    // each found span goes to the slot given by the number found before it
    always_comb begin
        logic [CNT_W:0] pre;
        pre = '0;
        for (int k = 0; k < MAX_SPANS; k++) begin
            spans[k] = '0;
        end
        for (int i = 0; i < LANES + 1; i++) begin
            if (cands[i].valid && pre < (CNT_W+1)'(MAX_SPANS)) begin
                spans[pre[CNT_W-1:0]] = cands[i].span;
            end
            pre = pre + (CNT_W+1)'(cands[i].valid);
        end
        count = pre[CNT_W-1:0];
    end

endmodule

// ===== src/brse_span_queue.sv =====
// span queue: per-byte release of up to four spans, drop on overflow, output fifo
// depends on brse_pkg; takes the registered spans of one byte per cycle
module brse_span_queue
    import brse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [CNT_W-1:0]      in_count,
    input  span_t                 in_spans [MAX_SPANS],
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output q_stat_t               stat
);

    // span storage and last-of-byte marks
    span_t span_mem [FIFO_DEPTH];
    logic  last_mem [FIFO_DEPTH];

    // write, release and read pointers; the step queue lies between rel and wr
    logic [PTR_W-1:0] wr_ptr_reg, rel_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next, rel_ptr_next, rd_ptr_next;
    logic [3:0]       step_cnt_reg, step_cnt_next;

    logic [3:0]       room, acc, total;
    logic [CNT_W-1:0] rel_n;
    logic [FIFO_AW-1:0] last_idx, last_off;
    logic               mark_old;

    // how many new spans fit and how many leave with this byte
    always_comb begin
        room  = 4'(STEP_Q_DEPTH) - step_cnt_reg;
        acc   = ({1'b0, in_count} < room) ? {1'b0, in_count} : room;
        total = step_cnt_reg + acc;
        rel_n = (total > 4'(OUT_PER_STEP)) ? CNT_W'(OUT_PER_STEP) : total[CNT_W-1:0];
        last_idx = rel_ptr_reg[FIFO_AW-1:0] + FIFO_AW'(rel_n) - FIFO_AW'(1);
        // offset of the final released span from the first new slot
        last_off = last_idx - wr_ptr_reg[FIFO_AW-1:0];
        mark_old = (rel_n != '0) && (last_off >= acc);
    end

    // pointer updates
    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        rel_ptr_next  = rel_ptr_reg;
        step_cnt_next = step_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        if (in_valid) begin
            wr_ptr_next   = wr_ptr_reg + PTR_W'(acc);
            rel_ptr_next  = rel_ptr_reg + PTR_W'(rel_n);
            step_cnt_next = total - {1'b0, rel_n};
        end
        if (m_tvalid && m_tready) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rel_ptr_reg  <= '0;
            rd_ptr_reg   <= '0;
            step_cnt_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            rel_ptr_reg  <= rel_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // store new spans with their marks, or mark a held span released by this byte
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            for (int k = 0; k < MAX_SPANS; k++) begin
                if (4'(k) < acc) begin
                    span_mem[wr_ptr_reg[FIFO_AW-1:0] + FIFO_AW'(k)] <= in_spans[k];
                    last_mem[wr_ptr_reg[FIFO_AW-1:0] + FIFO_AW'(k)] <=
                        (rel_n != '0) && (FIFO_AW'(k) == last_off);
                end
            end
            if (mark_old) begin
                last_mem[last_idx] <= 1'b1;
            end
        end
    end

    // released words go out in order
    assign m_tvalid = rd_ptr_reg != rel_ptr_reg;
    assign m_tdata  = {{(OUT_DATA_W-SPAN_BITS){1'b0}}, span_mem[rd_ptr_reg[FIFO_AW-1:0]]};
    assign m_tlast  = last_mem[rd_ptr_reg[FIFO_AW-1:0]];

    // room for the byte in flight plus one more
    assign stat.fill     = wr_ptr_reg - rd_ptr_reg;
    assign stat.space_ok = stat.fill <= PTR_W'(SPACE_LIMIT);

endmodule

// ===== src/bitmap_row_span_extractor.sv =====
// a span word passes the registered word stage (st_*_reg) and the fifo write in the queue
// before it is offered; a span held back waits for a later byte
// throughput: one byte per cycle while the output fifo holds 6 words or fewer; output is
// one word per cycle with m_tready high; dense bytes (up to 5 spans) stall at the fifo
// reset (aresetn low, synchronous): column, row, run state and fifo cleared, width 4096
// depends on brse_pkg, brse_lane, brse_merge, brse_span_queue
module bitmap_row_span_extractor
    import brse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: row width in pixels
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COL_W-1:0]      cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_bits
    input  logic                  s_tuser,   // [0] kind
    // span stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] span_left, [24:12] span_right,
                                             // [36:25] span_row, [39:37] zero
    output logic                  m_tlast    // last_span
);

    logic [COL_W-1:0]  width_reg, width_eff;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              open_reg, open_next;
    logic [LEFT_W-1:0] start_reg, start_next;

    logic              s_acc;
    q_stat_t           q_stat;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= COL_W'(MAX_WIDTH);
        end else if (cfg_valid) begin
            width_reg <= cfg_data;
        end
    end

    // width clamped to one through the maximum
    always_comb begin
        if (width_reg == '0) begin
            width_eff = COL_W'(1);
        end else if (width_reg > COL_W'(MAX_WIDTH)) begin
            width_eff = COL_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
    end

    // lane chain across the eight pixels of a word
    logic              open_ch [LANES+1];
    logic [LEFT_W-1:0] left_ch [LANES+1];
    cand_t             cands   [LANES+1];

    assign open_ch[0] = open_reg;
    assign left_ch[0] = start_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        brse_lane #(
            .LANE(g)
        ) u_lane (
            .column   (column_reg),
            .width    (width_eff),
            .row      (row_reg),
            .pixel    (s_tdata[PIX_W-1-g]),
            .open_in  (open_ch[g]),
            .left_in  (left_ch[g]),
            .open_out (open_ch[g+1]),
            .left_out (left_ch[g+1]),
            .cand     (cands[g])
        );
    end

    // column after this word and the row-end span
    logic [COL_W-1:0] col8, new_col;
    logic             row_end;

    always_comb begin
        col8 = column_reg + COL_W'(LANES);
        if (column_reg >= width_eff) begin
            new_col = column_reg;
        end else if (col8 <= width_eff) begin
            new_col = col8;
        end else begin
            new_col = width_eff;
        end
        row_end = new_col >= width_eff;
    end

    assign cands[LANES].valid      = row_end && open_ch[LANES];
    assign cands[LANES].span.left  = left_ch[LANES];
    assign cands[LANES].span.right = new_col;
    assign cands[LANES].span.row   = row_reg;

    span_t            m_spans [MAX_SPANS];
    logic [CNT_W-1:0] m_count;

    brse_merge u_merge (
        .cands (cands),
        .spans (m_spans),
        .count (m_count)
    );

    // scan state update per accepted word
    assign s_tready = q_stat.space_ok;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        open_next   = open_reg;
        start_next  = start_reg;
        if (s_acc) begin
            if (s_tuser) begin
                column_next = '0;
                row_next    = '0;
                open_next   = 1'b0;
                start_next  = '0;
            end else begin
                start_next = left_ch[LANES];
                if (row_end) begin
                    column_next = '0;
                    open_next   = 1'b0;
                    row_next    = (row_reg == ROW_W'(MAX_ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
                end else begin
                    column_next = new_col;
                    open_next   = open_ch[LANES];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
            open_reg   <= 1'b0;
            start_reg  <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
            open_reg   <= open_next;
            start_reg  <= start_next;
        end
    end

    // spans of one word, registered ahead of the queue
    logic             st_valid_reg;
    logic [CNT_W-1:0] st_count_reg;
    span_t            st_spans_reg [MAX_SPANS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st_count_reg <= s_tuser ? '0 : m_count;
            st_spans_reg <= m_spans;
        end
    end

    brse_span_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid_reg),
        .in_count (st_count_reg),
        .in_spans (st_spans_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (q_stat)
    );

    // fifo never holds more than its depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.fill <= PTR_W'(FIFO_DEPTH))
        else $error("span fifo overfilled");

    // one word never closes more than five spans
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg |-> st_count_reg <= CNT_W'(MAX_SPANS))
        else $error("too many spans for one word");

    // column stays within the widest row
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= COL_W'(MAX_WIDTH))
        else $error("column past the widest row");

    // a new image clears position and run state
    a_new_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (column_reg == '0 && row_reg == '0 && !open_reg))
        else $error("new image did not clear scan state");

endmodule

// ===== tb/tb_bitmap_row_span_extractor.sv =====
`timescale 1ns / 1ps
// testbench for bitmap_row_span_extractor: drives raster pixel words and width writes,
// tracks column, row and open run itself and checks every span word in order
// depends on brse_pkg and the rtl under src; needs nothing else
module tb_bitmap_row_span_extractor;
    import brse_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF    = 80;
    localparam int DRAIN_GAP   = 8;
    localparam int TAIL_GAP    = 12;
    localparam int BACKLOG_MAX = 8;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 36;
    localparam int REPORT_MAX  = 10;

    typedef enum logic { KIND_PIXELS = 1'b0, KIND_NEW_IMAGE = 1'b1 } word_kind_t;
    typedef enum logic { ROW_WIDTH = 1'b0, ROW_BYTE = 1'b1 } dir_op_t;

    // one span word as it should leave the block
    typedef struct packed {
        logic [LEFT_W-1:0] left;
        logic [COL_W-1:0]  right;
        logic [ROW_W-1:0]  row;
        logic              last;
    } span_word_t;

    // directed stimulus row; n_fixed < 0 means the tracker supplies the spans
    typedef struct packed {
        dir_op_t               op;
        word_kind_t            kind;
        logic [COL_W-1:0]      val;
        int                    n_fixed;
        span_word_t [1:0]      fixed;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COL_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // [7:0] pixel_bits
    logic                  s_tuser;   // [0] kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [11:0] left, [24:12] right, [36:25] row
    logic                  m_tlast;

    // raster tracker state
    logic [COL_W-1:0] width_reg;
    int               col_pos;
    int               row_pos;
    int               run_left;
    bit               run_live;
    span_word_t       span_backlog[$];
    span_word_t       step_spans[$];
    span_word_t       expected_spans[$];
    dir_row_t         dir_rows[$];

    bit src_idle_en   = 1'b1;
    bit snk_idle_en   = 1'b1;
    int hold_cycles   = 0;
    int idle_cycles   = 0;
    int words_sent    = 0;
    int widths_written = 0;
    int spans_seen    = 0;
    int mismatch_count = 0;

    bitmap_row_span_extractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // width as the block applies it: zero acts as one, above the maximum clamps
    function automatic int active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    // closed runs wait here until a word lets them out; a full backlog drops the newest
    function automatic void queue_span(int l, int r, int w);
        span_word_t s;
        if (span_backlog.size() < BACKLOG_MAX) begin
            s = {l[LEFT_W-1:0], r[COL_W-1:0], w[ROW_W-1:0], 1'b0};
            span_backlog.push_back(s);
        end
    endfunction

    function automatic void clear_raster();
        col_pos  = 0;
        row_pos  = 0;
        run_live = 1'b0;
        run_left = 0;
    endfunction

    // advance the raster by one word and collect the spans it releases
    function automatic void track_raster(word_kind_t k, logic [PIX_W-1:0] bits);
        int w;
        int n;
        int b;
        bit pix;
        span_word_t s;
        step_spans.delete();
        if (k == KIND_NEW_IMAGE) begin
            clear_raster();
        end else begin
            w = active_width();
            for (b = 0; b < PIX_W && col_pos < w; b++) begin
                pix = bits[PIX_W-1-b];
                if (pix && !run_live) begin
                    run_live = 1'b1;
                    run_left = col_pos;
                end else if (!pix && run_live) begin
                    queue_span(run_left, col_pos, row_pos);
                    run_live = 1'b0;
                end
                col_pos++;
            end
            // row end closes any open run
            if (col_pos >= w) begin
                if (run_live)
                    queue_span(run_left, col_pos, row_pos);
                run_live = 1'b0;
                col_pos  = 0;
                row_pos  = (row_pos + 1) % MAX_ROWS;
            end
        end
        // at most four spans leave per word, the final one marked
        n = (span_backlog.size() < OUT_PER_STEP) ? span_backlog.size() : OUT_PER_STEP;
        for (b = 0; b < n; b++) begin
            s = span_backlog.pop_front();
            s.last = (b == n - 1);
            step_spans.push_back(s);
        end
    endfunction

    function automatic dir_row_t cfg_row(logic [COL_W-1:0] v);
        dir_row_t d;
        d = '0;
        d.op = ROW_WIDTH;
        d.val = v;
        return d;
    endfunction

    function automatic dir_row_t byte_row(word_kind_t k, logic [PIX_W-1:0] bits);
        dir_row_t d;
        d = '0;
        d.op = ROW_BYTE;
        d.kind = k;
        d.val = COL_W'(bits);
        d.n_fixed = -1;
        return d;
    endfunction

    // row whose spans are typed in directly (n of them, last one marked)
    function automatic dir_row_t fixed_row(word_kind_t k, logic [PIX_W-1:0] bits, int n,
                                           int l0 = 0, int r0 = 0, int w0 = 0,
                                           int l1 = 0, int r1 = 0, int w1 = 0);
        dir_row_t d;
        d = byte_row(k, bits);
        d.n_fixed = n;
        d.fixed[0] = {l0[LEFT_W-1:0], r0[COL_W-1:0], w0[ROW_W-1:0], n == 1};
        d.fixed[1] = {l1[LEFT_W-1:0], r1[COL_W-1:0], w1[ROW_W-1:0], 1'b1};
        return d;
    endfunction

    // offer one pixel word, with random gaps, and log what it should release
    task automatic send_word(word_kind_t k, logic [PIX_W-1:0] bits, int n_fixed,
                             span_word_t [1:0] fixed);
        int j;
        while (src_idle_en && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= bits;
        do @(posedge aclk); while (!s_tready);
        track_raster(k, bits);
        words_sent++;
        if (n_fixed < 0) begin
            for (j = 0; j < step_spans.size(); j++)
                expected_spans.push_back(step_spans[j]);
        end else begin
            for (j = 0; j < n_fixed; j++)
                expected_spans.push_back(fixed[j]);
        end
    endtask

    task automatic write_width(logic [COL_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = v;
        widths_written++;
    endtask

    // stop offering, let every expected span out, then give the pipe time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // span receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= !(snk_idle_en && $urandom_range(0, 99) < 19);
            end
        end
    end

    // span checker
    always @(posedge aclk) begin
        span_t      got;
        span_word_t have;
        span_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got  = m_tdata[SPAN_BITS-1:0];
            have = {got.left, got.right, got.row, m_tlast};
            spans_seen++;
            if (expected_spans.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected span word: left %0d right %0d row %0d last %0d",
                             have.left, have.right, have.row, have.last);
            end else begin
                want = expected_spans.pop_front();
                if (want != have) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("span %0d l/r/row/last want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 spans_seen, want.left, want.right, want.row, want.last,
                                 have.left, have.right, have.row, have.last);
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               ph;
        int               i;
        int               style;
        logic [COL_W-1:0] wv;
        logic [PIX_W-1:0] bits;
        word_kind_t       k;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        width_reg = COL_W'(MAX_WIDTH);
        clear_raster();

        // directed rows, width 4096 after reset
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'hFF, 0));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h00, 1, 0, 8, 0));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h0F));
        // new image mid-row drops the open run
        dir_rows.push_back(fixed_row(KIND_NEW_IMAGE, 8'hFF, 0));
        // above the maximum acts as 4096
        dir_rows.push_back(cfg_row(13'h1FFF));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h80, 1, 0, 1, 0));
        // zero acts as one, and the column is already past it
        dir_rows.push_back(cfg_row(13'd0));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'hFF, 0));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h80, 1, 0, 1, 1));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h7F, 0));
        dir_rows.push_back(cfg_row(13'd8));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h81, 2, 0, 1, 3, 7, 8, 3));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h55));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'hAA));
        // five spans from one word, one held back until the next word
        dir_rows.push_back(cfg_row(13'd16));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h01));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h55));
        dir_rows.push_back(byte_row(KIND_NEW_IMAGE, 8'h00));
        // width lowered mid-row closes the run at the current column
        dir_rows.push_back(cfg_row(13'd24));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h0F));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'hFF));
        dir_rows.push_back(cfg_row(13'd10));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'h00, 1, 4, 16, 0));
        // width not a multiple of eight: trailing bits ignored
        dir_rows.push_back(cfg_row(13'd13));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'hFF));
        dir_rows.push_back(fixed_row(KIND_PIXELS, 8'hFF, 1, 0, 13, 1));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'h07));
        dir_rows.push_back(byte_row(KIND_PIXELS, 8'hF8));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].op == ROW_WIDTH) begin
                settle();
                write_width(dir_rows[i].val);
            end else begin
                send_word(dir_rows[i].kind, dir_rows[i].val[PIX_W-1:0],
                          dir_rows[i].n_fixed, dir_rows[i].fixed);
            end
        end

        // random phases: fresh width, mostly a new image, then raster words
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0: wv = '0;
                1: wv = 13'h1FFF;
                2: wv = 13'd1;
                3: wv = COL_W'(8 * $urandom_range(1, 4));
                4: wv = COL_W'($urandom_range(MAX_WIDTH + 1, 8190));
                5: wv = COL_W'(MAX_WIDTH);
                default: wv = COL_W'($urandom_range(2, 40));
            endcase
            settle();
            write_width(wv);
            // one phase runs with no gaps on either side
            src_idle_en = (ph != 2);
            snk_idle_en = (ph != 2);
            // one phase holds the receiver off while dense words keep coming
            if (ph == 5)
                hold_cycles = HOLD_OFF;
            if ($urandom_range(0, 3) != 0)
                send_word(KIND_NEW_IMAGE, PIX_W'($urandom_range(0, 255)), -1, '0);
            for (i = 0; i < PHASE_WORDS; i++) begin
                k = ($urandom_range(0, 99) < 4) ? KIND_NEW_IMAGE : KIND_PIXELS;
                style = (ph == 5) ? $urandom_range(0, 1) : $urandom_range(0, 6);
                case (style)
                    0: bits = 8'h55;
                    1: bits = 8'hAA;
                    2: bits = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    3: bits = 8'h80 >> $urandom_range(0, 7);
                    default: bits = PIX_W'($urandom_range(0, 255));
                endcase
                send_word(k, bits, -1, '0);
            end
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;

        settle();
        repeat (TAIL_GAP) @(posedge aclk);
        mismatch_count += expected_spans.size();

        $display("covered %0d pixel and new-image words, %0d width writes,", words_sent,
                 widths_written);
        $display("width clamping, width lowered mid-row, dense words, hold-off; %0d spans checked",
                 spans_seen);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
